FILE: sv/median_split_contrast_assert.svh
// Assertion macros for the contrast block.
`ifndef MEDIAN_SPLIT_CONTRAST_ASSERT_SVH
`define MEDIAN_SPLIT_CONTRAST_ASSERT_SVH

// same-cycle implication
`define MSC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/msc_pkg.sv
package msc_pkg;

   localparam int CHAN_W = 8;
   localparam int GAIN_W = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int GRAY_ACC_W = 22;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_GAIN = 1'b1;

   localparam logic OP_COUNT = 1'b0;
   localparam logic OP_APPLY = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

   localparam logic [GRAY_ACC_W-1:0] GRAY_K_RED = 22'd4899;
   localparam logic [GRAY_ACC_W-1:0] GRAY_K_GREEN = 22'd9617;
   localparam logic [GRAY_ACC_W-1:0] GRAY_K_BLUE = 22'd1868;
   localparam logic [GRAY_ACC_W-1:0] GRAY_ROUND = 22'd8192;

   typedef struct packed {
      logic              opcode;
      logic [CHAN_W-1:0] pixel_blue;
      logic [CHAN_W-1:0] pixel_green;
      logic [CHAN_W-1:0] pixel_red;
      logic              last_pixel;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] median_level;
      logic              frame_end;
   } rsp_word_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } hist_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_GRAY,
      S_READ,
      S_WRITE,
      S_SCAN_START,
      S_SCAN,
      S_MUL,
      S_OUT
   } state_type;

   function automatic logic [CHAN_W-1:0] gray_of(input req_word_type w);
      logic [GRAY_ACC_W-1:0] acc;
      acc = GRAY_ACC_W'(w.pixel_red) * GRAY_K_RED
          + GRAY_ACC_W'(w.pixel_green) * GRAY_K_GREEN
          + GRAY_ACC_W'(w.pixel_blue) * GRAY_K_BLUE
          + GRAY_ROUND;
      return acc[GRAY_ACC_W-1:GRAY_ACC_W-CHAN_W];
   endfunction

endpackage

FILE: sv/msc_hist_ram.sv
module msc_hist_ram #(
   parameter int GRAY_LEVELS = 256,
   parameter int CW = 21
) (
   input  logic                            clock,
   input  logic                            reset,
   input  msc_pkg::hist_cmd_type           cmd,
   input  logic [$clog2(GRAY_LEVELS)-1:0]  rd_addr,
   input  logic [$clog2(GRAY_LEVELS)-1:0]  wr_addr,
   input  logic [CW-1:0]                   wr_data,
   output logic [CW-1:0]                   rd_data
);
   import msc_pkg::*;

   localparam int AW = $clog2(GRAY_LEVELS);

   logic [CW-1:0] mem [GRAY_LEVELS];
   logic [CW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr_ff;
   logic [GRAY_LEVELS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // cleared bins read as zero
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = valid_ff[rd_addr_ff] ? rd_data_ff : '0;

endmodule

FILE: sv/msc_scale.sv
module msc_scale (
   input  logic                  clock,
   input  logic                  load,
   input  msc_pkg::req_word_type pixel,
   input  logic [15:0]           gain,
   output logic [7:0]            out_blue,
   output logic [7:0]            out_green,
   output logic [7:0]            out_red
);
   import msc_pkg::*;

   localparam int PROD_W = CHAN_W + GAIN_W;

   logic [PROD_W-1:0] blue_prod_ff;
   logic [PROD_W-1:0] green_prod_ff;
   logic [PROD_W-1:0] red_prod_ff;

   function automatic logic [CHAN_W-1:0] sat(input logic [PROD_W-1:0] p);
      logic [GAIN_W-1:0] v;
      v = p[PROD_W-1:CHAN_W];
      return (v > GAIN_W'(255)) ? '1 : v[CHAN_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (load) begin
         blue_prod_ff <= PROD_W'(pixel.pixel_blue) * PROD_W'(gain);
         green_prod_ff <= PROD_W'(pixel.pixel_green) * PROD_W'(gain);
         red_prod_ff <= PROD_W'(pixel.pixel_red) * PROD_W'(gain);
      end
   end

   assign out_blue = sat(blue_prod_ff);
   assign out_green = sat(green_prod_ff);
   assign out_red = sat(red_prod_ff);

endmodule

FILE: sv/median_split_contrast.sv
// Median-split contrast stretch on BGR pixels, two passes per frame.
// Input: raise start with req_word; the word is taken on an edge where busy is
// low. opcode 0 (count pass) adds the pixel's gray level to a histogram; on
// the word marked last_pixel the histogram is scanned for the median and then
// cleared. opcode 1 (apply pass) scales the pixel by inverse gain when its
// gray level is below the median, else by gain, saturating at 255.
// Output: rsp_strobe is high for one cycle with rsp_word, once per apply word;
// count words give no output. The receiver cannot hold results off.
// Flow: a word holds busy through the gray state, then histogram read and write,
// or gray, multiply, saturate; the next word is taken only once back in idle,
// so a new word is not accepted before the last is done. The apply result is
// registered from the saturate step and shown with rsp_strobe. A last count
// word adds a scan start and a scan, one bin per cycle off the memory port.
// Config: csr_write_en, csr_index, csr_data write gain (0) or inverse gain (1)
// at once; write only while idle.
// Reset: histogram, pixel count and median clear to zero, gains to 1.0.
`include "median_split_contrast_assert.svh"
module median_split_contrast #(
   parameter int GRAY_LEVELS = 256,
   parameter int MAX_PIXELS_LOG2 = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  msc_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output msc_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_en,
   input  logic [msc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [msc_pkg::GAIN_W-1:0]      csr_data
);
   import msc_pkg::*;

   localparam int AW = $clog2(GRAY_LEVELS);
   localparam int CW = MAX_PIXELS_LOG2 + 1;
   localparam logic [AW-1:0] TOP_BIN = AW'(GRAY_LEVELS - 1);

   state_type state_ff, state_in;
   req_word_type req_ff;
   logic [CHAN_W-1:0] gray_ff;
   logic [CW-1:0] total_ff;
   logic [CHAN_W-1:0] median_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [GAIN_W-1:0] inv_gain_ff;
   logic [AW-1:0] scan_idx_ff;
   logic [CW:0] sum_ff;
   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   hist_cmd_type hist_cmd;
   logic [AW-1:0] hist_rd_addr;
   logic [AW-1:0] gray_bin;
   logic [CW-1:0] hist_rd_data;
   logic [CW-1:0] hist_wr_data;
   logic [CW:0] sum_next;
   logic scan_done;
   logic accept;
   logic [GAIN_W-1:0] sel_gain;
   logic [CHAN_W-1:0] sc_blue, sc_green, sc_red;

   assign accept = start && (state_ff == S_IDLE);
   assign gray_bin = (32'(gray_ff) >= 32'(GRAY_LEVELS)) ? TOP_BIN : AW'(gray_ff);
   assign hist_wr_data = (hist_rd_data == '1) ? hist_rd_data : hist_rd_data + 1'b1;
   assign sum_next = sum_ff + (CW+1)'(hist_rd_data);
   assign scan_done = (state_ff == S_SCAN) &&
      ((sum_next >= (CW+1)'(total_ff >> 1)) || (scan_idx_ff == TOP_BIN));
   assign sel_gain = (gray_ff < median_ff) ? inv_gain_ff : gain_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_GRAY;
         end
         S_GRAY: begin
            state_in = (req_ff.opcode == OP_COUNT) ? S_READ : S_MUL;
         end
         S_READ: state_in = S_WRITE;
         S_WRITE: begin
            state_in = req_ff.last_pixel ? S_SCAN_START : S_IDLE;
         end
         S_SCAN_START: state_in = S_SCAN;
         S_SCAN: begin
            if (scan_done) state_in = S_IDLE;
         end
         S_MUL: state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      hist_cmd = '0;
      hist_rd_addr = gray_bin;
      case (state_ff)
         S_READ: hist_cmd.rd_en = 1'b1;
         S_WRITE: hist_cmd.wr_en = 1'b1;
         S_SCAN_START: begin
            hist_cmd.rd_en = 1'b1;
            hist_rd_addr = '0;
         end
         S_SCAN: begin
            hist_cmd.rd_en = 1'b1;
            hist_cmd.clear = scan_done;
            hist_rd_addr = scan_idx_ff + 1'b1;
         end
         default: hist_cmd = '0;
      endcase
      busy = (state_ff != S_IDLE);
      rsp_strobe_in = (state_ff == S_OUT);
      rsp_word_in.out_blue = sc_blue;
      rsp_word_in.out_green = sc_green;
      rsp_word_in.out_red = sc_red;
      rsp_word_in.median_level = median_ff;
      rsp_word_in.frame_end = req_ff.last_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         median_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (state_ff == S_WRITE && total_ff != '1) begin
            total_ff <= total_ff + 1'b1;
         end else if (scan_done) begin
            total_ff <= '0;
         end
         if (scan_done) begin
            median_ff <= CHAN_W'(scan_idx_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         inv_gain_ff <= GAIN_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GAIN: gain_ff <= csr_data;
            CSR_INV_GAIN: inv_gain_ff <= csr_data;
            default: gain_ff <= gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_word;
      if (state_ff == S_GRAY) gray_ff <= gray_of(req_ff);
      if (state_ff == S_SCAN_START) begin
         scan_idx_ff <= '0;
         sum_ff <= '0;
      end else if (state_ff == S_SCAN) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         sum_ff <= sum_next;
      end
      if (rsp_strobe_in) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word = rsp_word_ff;

   msc_hist_ram #(
      .GRAY_LEVELS(GRAY_LEVELS),
      .CW(CW)
   ) u_hist (
      .clock(clock),
      .reset(reset),
      .cmd(hist_cmd),
      .rd_addr(hist_rd_addr),
      .wr_addr(gray_bin),
      .wr_data(hist_wr_data),
      .rd_data(hist_rd_data)
   );

   msc_scale u_scale (
      .clock(clock),
      .load(state_ff == S_MUL),
      .pixel(req_ff),
      .gain(sel_gain),
      .out_blue(sc_blue),
      .out_green(sc_green),
      .out_red(sc_red)
   );

   `MSC_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accepted word did not raise busy")
   `MSC_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "back-to-back strobe")
   `MSC_ASSERT_IMPLY(a_strobe_src, clock, reset, rsp_strobe,
      $past(state_ff == S_OUT), "stray strobe")
   `MSC_ASSERT_NEXT(a_scan_ends, clock, reset,
      (state_ff == S_SCAN) && (scan_idx_ff == TOP_BIN),
      state_ff == S_IDLE, "scan ran past top bin")

endmodule
